@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/gcomp_pkg.sv @@
`timescale 1ns / 1ps

package gcomp_pkg;

   localparam int GROUP_W = 12;
   localparam int CFG_W = 7;
   localparam int CSR_IDX_W = 1;
   localparam int IDX_EXT_W = 10;

   localparam logic [GROUP_W-1:0] COUNT_MAX = 12'hFFF;
   localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS = 1'b1;

   localparam logic [1:0] DIR_UP = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;
   localparam logic [1:0] DIR_LEFT = 2'd3;

   localparam int CELL_WALL = 1;
   localparam int CELL_SEEN = 0;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN_RD  = 9'b000000010,
      S_SCAN_CHK = 9'b000000100,
      S_NEXT     = 9'b000001000,
      S_POP      = 9'b000010000,
      S_BASE     = 9'b000100000,
      S_NB_RD    = 9'b001000000,
      S_NB_CHK   = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

endpackage

@@ rtl/grid_component_counter.sv @@
// An item that does not complete the grid is written to the cell memory and busy stays low,
// so cells load at one per cycle. The item that completes the grid starts the count:
// a scan that reads and checks every grid cell and, for each new group, a flood fill that
// pops cells off the stack and reads their four neighbors; cell and stack reads are registered.
// The count appears on rsp_valid for one cycle, then busy drops; results cannot be stalled.
// Reset is synchronous and active high; it restarts the grid load and sets both sizes to 64.
`timescale 1ns / 1ps

module grid_component_counter
   import gcomp_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_wall,
   output logic                 rsp_valid,
   output logic [GROUP_W-1:0]   rsp_group_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
   localparam int TOT_W = $clog2(CELL_CAP + 1);
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int COLS_W = $clog2(MAX_COLS + 1);
   localparam int SP_W = ADDR_W + 1;
   localparam int ENT_W = RW + CW;

   state_type state_ff, state_in;
   logic [CFG_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [ADDR_W-1:0] load_ff, load_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [RW-1:0] scan_r_ff, scan_r_in;
   logic [CW-1:0] scan_c_ff, scan_c_in;
   logic [SP_W-1:0] top_ff, top_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [RW-1:0] pr_ff, pr_in, nr_ff, nr_in;
   logic [CW-1:0] pc_ff, pc_in, nc_ff, nc_in;
   logic [ADDR_W-1:0] base_ff, base_in, nb_addr_ff, nb_addr_in;
   logic [1:0] dir_ff, dir_in;

   logic [ROWS_W-1:0] rows_eff;
   logic [COLS_W-1:0] cols_eff;
   logic [TOT_W-1:0] total;

   logic g_wr_en, g_rd_en;
   logic [ADDR_W-1:0] g_wr_addr, g_rd_addr;
   logic [1:0] g_wr_data, g_rd_data;
   logic s_wr_en, s_rd_en;
   logic [ADDR_W-1:0] s_wr_addr, s_rd_addr;
   logic [ENT_W-1:0] s_wr_data, s_rd_data;

   logic nb_ok, nb_sub, cell_hit, scan_last, last_dir;
   logic [RW-1:0] nb_r;
   logic [CW-1:0] nb_c;
   logic [TOT_W-1:0] nb_opnd, nb_sum;
   logic [SP_W-1:0] top_dec;
   logic [GROUP_W-1:0] group_inc;

   gcomp_ram #(.WIDTH(2), .DEPTH(CELL_CAP)) u_grid_ram (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data),
      .rd_en   (g_rd_en),
      .rd_addr (g_rd_addr),
      .rd_data (g_rd_data)
   );

   gcomp_ram #(.WIDTH(ENT_W), .DEPTH(CELL_CAP)) u_stack_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = ROWS_W'(1);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         rows_eff = ROWS_W'(MAX_ROWS);
      end else begin
         rows_eff = ROWS_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_eff = COLS_W'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = COLS_W'(MAX_COLS);
      end else begin
         cols_eff = COLS_W'(cols_ff);
      end
      total = TOT_W'(TOT_W'(rows_eff) * TOT_W'(cols_eff));
   end

   // The neighbor address comes from one shared add/subtract on the popped cell's address.
   always_comb begin
      nb_ok = 1'b0;
      nb_sub = 1'b0;
      nb_r = pr_ff;
      nb_c = pc_ff;
      nb_opnd = TOT_W'(1);
      case (dir_ff)
         DIR_UP: begin
            nb_ok = (pr_ff != '0);
            nb_sub = 1'b1;
            nb_r = pr_ff - RW'(1);
            nb_opnd = TOT_W'(cols_eff);
         end
         DIR_RIGHT: begin
            nb_ok = (IDX_EXT_W'(pc_ff) + IDX_EXT_W'(1)) < IDX_EXT_W'(cols_eff);
            nb_c = pc_ff + CW'(1);
         end
         DIR_DOWN: begin
            nb_ok = (IDX_EXT_W'(pr_ff) + IDX_EXT_W'(1)) < IDX_EXT_W'(rows_eff);
            nb_r = pr_ff + RW'(1);
            nb_opnd = TOT_W'(cols_eff);
         end
         DIR_LEFT: begin
            nb_ok = (pc_ff != '0);
            nb_sub = 1'b1;
            nb_c = pc_ff - CW'(1);
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
      nb_sum = nb_sub ? (TOT_W'(base_ff) - nb_opnd) : (TOT_W'(base_ff) + nb_opnd);
   end

   assign cell_hit = g_rd_data[CELL_WALL] && !g_rd_data[CELL_SEEN];
   assign scan_last = (TOT_W'(scan_addr_ff) + TOT_W'(1)) == total;
   assign last_dir = (dir_ff == DIR_LEFT);
   assign top_dec = top_ff - SP_W'(1);
   assign group_inc = (group_ff == COUNT_MAX) ? group_ff : group_ff + GROUP_W'(1);

   always_comb begin
      state_in = state_ff;
      rows_in = rows_ff;
      cols_in = cols_ff;
      load_in = load_ff;
      scan_addr_in = scan_addr_ff;
      scan_r_in = scan_r_ff;
      scan_c_in = scan_c_ff;
      top_in = top_ff;
      group_in = group_ff;
      pr_in = pr_ff;
      pc_in = pc_ff;
      nr_in = nr_ff;
      nc_in = nc_ff;
      base_in = base_ff;
      nb_addr_in = nb_addr_ff;
      dir_in = dir_ff;
      g_wr_en = 1'b0;
      g_wr_addr = scan_addr_ff;
      g_wr_data = 2'b11;
      g_rd_en = 1'b0;
      g_rd_addr = scan_addr_ff;
      s_wr_en = 1'b0;
      s_wr_addr = top_ff[ADDR_W-1:0];
      s_wr_data = {scan_r_ff, scan_c_ff};
      s_rd_en = 1'b0;
      s_rd_addr = top_dec[ADDR_W-1:0];

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROWS: rows_in = csr_wdata;
            REG_COLS: cols_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               // Loading a cell also clears its seen flag for the coming count.
               g_wr_en = 1'b1;
               g_wr_addr = load_ff;
               g_wr_data = {req_wall, 1'b0};
               if ((TOT_W'(load_ff) + TOT_W'(1)) >= total) begin
                  load_in = '0;
                  scan_addr_in = '0;
                  scan_r_in = '0;
                  scan_c_in = '0;
                  top_in = '0;
                  group_in = '0;
                  state_in = S_SCAN_RD;
               end else begin
                  load_in = load_ff + ADDR_W'(1);
               end
            end
         end
         S_SCAN_RD: begin
            g_rd_en = 1'b1;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (cell_hit) begin
               group_in = group_inc;
               g_wr_en = 1'b1;
               s_wr_en = 1'b1;
               top_in = top_ff + SP_W'(1);
               state_in = S_POP;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (scan_last) begin
               state_in = S_DONE;
            end else begin
               scan_addr_in = scan_addr_ff + ADDR_W'(1);
               if ((IDX_EXT_W'(scan_c_ff) + IDX_EXT_W'(1)) == IDX_EXT_W'(cols_eff)) begin
                  scan_c_in = '0;
                  scan_r_in = scan_r_ff + RW'(1);
               end else begin
                  scan_c_in = scan_c_ff + CW'(1);
               end
               state_in = S_SCAN_RD;
            end
         end
         S_POP: begin
            if (top_ff == '0) begin
               state_in = S_NEXT;
            end else begin
               s_rd_en = 1'b1;
               top_in = top_dec;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            pr_in = s_rd_data[ENT_W-1:CW];
            pc_in = s_rd_data[CW-1:0];
            base_in = ADDR_W'(TOT_W'(s_rd_data[ENT_W-1:CW]) * TOT_W'(cols_eff)
                              + TOT_W'(s_rd_data[CW-1:0]));
            dir_in = DIR_UP;
            state_in = S_NB_RD;
         end
         S_NB_RD: begin
            if (nb_ok) begin
               g_rd_en = 1'b1;
               g_rd_addr = nb_sum[ADDR_W-1:0];
               nb_addr_in = nb_sum[ADDR_W-1:0];
               nr_in = nb_r;
               nc_in = nb_c;
               state_in = S_NB_CHK;
            end else if (last_dir) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end
         S_NB_CHK: begin
            if (cell_hit) begin
               g_wr_en = 1'b1;
               g_wr_addr = nb_addr_ff;
               s_wr_en = 1'b1;
               s_wr_data = {nr_ff, nc_ff};
               top_in = top_ff + SP_W'(1);
            end
            if (last_dir) begin
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
               state_in = S_NB_RD;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
         load_ff <= '0;
         top_ff <= '0;
         group_ff <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         load_ff <= load_in;
         top_ff <= top_in;
         group_ff <= group_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      scan_r_ff <= scan_r_in;
      scan_c_ff <= scan_c_in;
      pr_ff <= pr_in;
      pc_ff <= pc_in;
      nr_ff <= nr_in;
      nc_ff <= nc_in;
      base_ff <= base_in;
      nb_addr_ff <= nb_addr_in;
      dir_ff <= dir_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_group_count = group_ff;
   assign csr_ready = !busy;

endmodule

@@ rtl/gcomp_ram.sv @@
`timescale 1ns / 1ps

module gcomp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/gcomp_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcomp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // A count is shown only while the block is busy, for a single cycle, and the block is
   // free again right after it.
   `ASSERT_SAME(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_NEXT(a_idle_after_rsp, clock, reset, rsp_valid, !busy)
   // A transfer never produces its count in the very next cycle.
   `ASSERT_NEXT(a_no_instant_rsp, clock, reset, start && !busy, !rsp_valid)
   // The block becomes busy only because a transfer was taken.
   `ASSERT_SAME(a_busy_from_start, clock, reset, $rose(busy), $past(start))

endmodule

bind grid_component_counter gcomp_checker u_gcomp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

@@ test/tb_grid_component_counter.sv @@
`timescale 1ns / 1ps

module tb_grid_component_counter;
   import gcomp_pkg::*;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
   localparam int CSR_HOLD = 4;
   localparam int TARGET_CELLS = 850;
   localparam int BOARD_SIZE = 32;

   typedef struct packed {
      logic                 is_csr;
      logic                 wall;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     wdata;
   } stim_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_wall = 1'b0;
   logic                 rsp_valid;
   logic [GROUP_W-1:0]   rsp_group_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   stim_type           stim_q [$];
   logic [GROUP_W-1:0] exp_counts [$];

   bit                 grid_cells [CELL_CAP];
   logic [CFG_W-1:0]   size_rows;
   logic [CFG_W-1:0]   size_cols;
   int                 load_pos;
   int                 quiet_cycles;

   int cells_sent;
   int size_writes;
   int results_checked;
   int fail_count;

   logic [CFG_W-1:0] gen_rows;
   logic [CFG_W-1:0] gen_cols;
   int               gen_load;
   int               gen_cells;

   grid_component_counter #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_wall(req_wall),
      .rsp_valid(rsp_valid),
      .rsp_group_count(rsp_group_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int eff_size(input logic [CFG_W-1:0] raw, input int hi);
      if (raw < 1) return 1;
      if (raw > hi) return hi;
      return int'(raw);
   endfunction

   function automatic logic [GROUP_W-1:0] count_wall_groups(input int rows, input int cols);
      bit visited [CELL_CAP];
      int pending [$];
      int drow [4] = '{-1, 0, 1, 0};
      int dcol [4] = '{0, 1, 0, -1};
      int groups;
      int p, r, c, nr, nc, q;
      groups = 0;
      for (int idx = 0; idx < rows * cols; idx++) begin
         if (grid_cells[idx] && !visited[idx]) begin
            if (groups < COUNT_MAX) groups++;
            visited[idx] = 1'b1;
            pending.insert(pending.size(), idx);
            while (pending.size() > 0) begin
               p = pending.pop_back();
               r = p / cols;
               c = p % cols;
               for (int d = 0; d < 4; d++) begin
                  nr = r + drow[d];
                  nc = c + dcol[d];
                  if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
                     q = nr * cols + nc;
                     if (grid_cells[q] && !visited[q]) begin
                        visited[q] = 1'b1;
                        pending.insert(pending.size(), q);
                     end
                  end
               end
            end
         end
      end
      return groups[GROUP_W-1:0];
   endfunction

   task automatic push_size(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      stim_type item;
      item = '0;
      item.is_csr = 1'b1;
      item.index = idx;
      item.wdata = value;
      stim_q.insert(stim_q.size(), item);
      if (idx == REG_ROWS) gen_rows = value;
      else gen_cols = value;
   endtask

   task automatic push_cell(input logic wall);
      stim_type item;
      item = '0;
      item.wall = wall;
      stim_q.insert(stim_q.size(), item);
      gen_cells++;
      gen_load++;
      if (gen_load >= eff_size(gen_rows, MAX_ROWS) * eff_size(gen_cols, MAX_COLS))
         gen_load = 0;
   endtask

   task automatic push_grid_rest(input int density);
      do begin
         push_cell($urandom_range(99) < density);
      end while (gen_load != 0);
   endtask

   always @(posedge clock) begin : drive_proc
      logic                 nxt_start;
      logic                 nxt_wall;
      logic                 nxt_csr_valid;
      logic [CSR_IDX_W-1:0] nxt_index;
      logic [CFG_W-1:0]     nxt_wdata;
      logic                 allow_idle;
      stim_type             item;
      int                   total;
      if (reset) begin
         start <= 1'b0;
         req_wall <= 1'b0;
         csr_valid <= 1'b0;
         csr_index <= '0;
         csr_wdata <= '0;
         size_rows = SIZE_RESET;
         size_cols = SIZE_RESET;
         load_pos = 0;
         quiet_cycles = 0;
      end else begin
         if (start && !busy) begin
            total = eff_size(size_rows, MAX_ROWS) * eff_size(size_cols, MAX_COLS);
            if (load_pos < CELL_CAP) grid_cells[load_pos] = req_wall;
            load_pos++;
            if (load_pos >= total) begin
               exp_counts.insert(exp_counts.size(),
                                 count_wall_groups(eff_size(size_rows, MAX_ROWS),
                                                   eff_size(size_cols, MAX_COLS)));
               load_pos = 0;
            end
            cells_sent++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ROWS) size_rows = csr_wdata;
            else size_cols = csr_wdata;
            size_writes++;
         end
         if (exp_counts.size() == 0 && !busy && !rsp_valid) quiet_cycles++;
         else quiet_cycles = 0;

         nxt_start = start && busy;
         nxt_csr_valid = csr_valid && !csr_ready;
         nxt_wall = req_wall;
         nxt_index = csr_index;
         nxt_wdata = csr_wdata;
         if (!nxt_start && !nxt_csr_valid) begin
            nxt_wall = 1'($urandom_range(1, 0));
            nxt_index = CSR_IDX_W'($urandom);
            nxt_wdata = CFG_W'($urandom);
            allow_idle = !(cells_sent >= 700 && cells_sent < 1100);
            if (stim_q.size() > 0 && !(allow_idle && $urandom_range(99) < 16)) begin
               if (!stim_q[0].is_csr) begin
                  item = stim_q.pop_front();
                  nxt_start = 1'b1;
                  nxt_wall = item.wall;
               end else if (quiet_cycles >= CSR_HOLD) begin
                  item = stim_q.pop_front();
                  nxt_csr_valid = 1'b1;
                  nxt_index = item.index;
                  nxt_wdata = item.wdata;
               end
            end
         end
         start <= nxt_start;
         req_wall <= nxt_wall;
         csr_valid <= nxt_csr_valid;
         csr_index <= nxt_index;
         csr_wdata <= nxt_wdata;
      end
   end

   always @(posedge clock) begin : check_proc
      logic [GROUP_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (exp_counts.size() == 0) begin
            $display("%0t: unexpected group count, expected none, actual %0d",
                     $time, rsp_group_count);
            fail_count++;
         end else begin
            want = exp_counts.pop_front();
            results_checked++;
            if (rsp_group_count !== want) begin
               $display("%0t: group count mismatch, expected %0d, actual %0d",
                        $time, want, rsp_group_count);
               fail_count++;
            end
         end
      end
   end

   initial begin : stim_proc
      int pick;
      int rows, cols, k;
      gen_rows = SIZE_RESET;
      gen_cols = SIZE_RESET;
      gen_load = 0;
      gen_cells = 0;

      // Single cells, a clamped row count and the smallest square shapes.
      push_size(REG_ROWS, 7'd1);
      push_size(REG_COLS, 7'd1);
      push_cell(1'b1);
      push_cell(1'b0);
      push_size(REG_ROWS, 7'd0);
      push_size(REG_COLS, 7'd3);
      push_cell(1'b1);
      push_cell(1'b0);
      push_cell(1'b1);
      push_size(REG_ROWS, 7'd2);
      push_size(REG_COLS, 7'd2);
      push_cell(1'b1);
      push_cell(1'b1);
      push_cell(1'b1);
      push_cell(1'b1);
      push_cell(1'b1);
      push_cell(1'b0);
      push_cell(1'b0);
      push_cell(1'b1);
      // Shrinking the grid after five cells makes the next cell complete it.
      push_size(REG_ROWS, 7'd3);
      push_size(REG_COLS, 7'd3);
      push_cell(1'b1);
      push_cell(1'b0);
      push_cell(1'b1);
      push_cell(1'b0);
      push_cell(1'b1);
      push_size(REG_COLS, 7'd1);
      push_cell(1'b0);

      push_size(REG_ROWS, 7'd127);
      push_size(REG_COLS, 7'd1);
      push_grid_rest(50);
      push_size(REG_ROWS, 7'd1);
      push_size(REG_COLS, 7'd65);
      push_grid_rest(50);

      while (gen_cells < TARGET_CELLS) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            rows = ($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1);
            cols = ($urandom_range(19) == 0) ? 0 : $urandom_range(8, 1);
            push_size(REG_ROWS, rows[CFG_W-1:0]);
            push_size(REG_COLS, cols[CFG_W-1:0]);
         end else if (pick < 80) begin
            push_size(REG_ROWS, 7'($urandom_range(16, 9)));
            push_size(REG_COLS, 7'($urandom_range(16, 9)));
         end else if (pick < 90) begin
            push_size($urandom_range(1, 0) ? REG_ROWS : REG_COLS, 7'($urandom_range(8, 1)));
         end else begin
            rows = eff_size(gen_rows, MAX_ROWS) * eff_size(gen_cols, MAX_COLS);
            k = (rows > 1) ? $urandom_range(rows - 1, 1) : 0;
            for (int i = 0; i < k; i++) push_cell(1'($urandom_range(1, 0)));
            push_size($urandom_range(1, 0) ? REG_ROWS : REG_COLS, 7'($urandom_range(8, 1)));
         end
         push_grid_rest($urandom_range(100, 0));
      end

      // A checkerboard makes every wall cell a group of its own.
      push_size(REG_ROWS, 7'(BOARD_SIZE));
      push_size(REG_COLS, 7'(BOARD_SIZE));
      for (int r = 0; r < BOARD_SIZE; r++)
         for (int c = 0; c < BOARD_SIZE; c++)
            push_cell(((r + c) % 2) == 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (stim_q.size() != 0 || start || csr_valid) @(negedge clock);
      while (exp_counts.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("Checked %0d group counts over %0d cells with %0d size writes.",
               results_checked, cells_sent, size_writes);
      $display("Shapes ran from 1x1 to full-length rows and columns and a 32x32 checkerboard,");
      $display("with clamped sizes and a resize in mid-grid.");
      if (fail_count == 0 && exp_counts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog_proc
      #10_000_000;
      $display("Run timed out with %0d group counts outstanding.", exp_counts.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/gcomp_pkg.sv
rtl/gcomp_ram.sv
rtl/grid_component_counter.sv
rtl/gcomp_checker.sv
test/tb_grid_component_counter.sv
